/* rtl/bearing_to_equirectangular_assert.svh */
// Assertion macros for the bearing-to-equirectangular projection.
// Every macro expects clk and rst_n in the scope where it is used.
`ifndef BEARING_TO_EQUIRECTANGULAR_ASSERT_SVH
`define BEARING_TO_EQUIRECTANGULAR_ASSERT_SVH

// Checks the consequent in the same cycle as the antecedent.
`define B2E_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bearing_to_equirectangular: assertion failed");

// Checks the consequent in the cycle after the antecedent.
`define B2E_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bearing_to_equirectangular: assertion failed");

`endif

/* rtl/b2e_pkg.sv */
// Package for the bearing-to-equirectangular projection: widths, register
// codes, CORDIC arctangent table and stage types. No dependencies.
`timescale 1ns / 1ps

package b2e_pkg;

    localparam int COORD_BITS    = 18;
    localparam int FRAC_BITS     = 8;
    localparam int MAX_DIM       = 8192;
    localparam int CORDIC_STAGES = 18;

    localparam int DIM_BITS  = 14;
    localparam int U_BITS    = 21;
    localparam int V_BITS    = 22;
    localparam int ANG_W     = 32;
    localparam int PRESCALE  = 28;
    localparam int LAT_GUARD = 32 - COORD_BITS;

    localparam int SQ_W        = 2 * COORD_BITS;
    localparam int SUM_W       = 64;
    localparam int SQRT_STAGES = SUM_W / 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int ZS_W        = COORD_BITS + LAT_GUARD;
    localparam int LON_W       = COORD_BITS + PRESCALE + 4;
    localparam int LAT_W       = 64;
    localparam int D_W         = ANG_W;
    localparam int PROD_W      = DIM_BITS + ANG_W;

    localparam logic [ANG_W-1:0] ANG_HALF = ANG_W'(64'h8000_0000);

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // round(atan(2^-i) / (2 pi) * 2^32)
    localparam logic [ANG_W-1:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [LON_W-1:0] x;
        logic signed [LON_W-1:0] y;
        logic [ANG_W-1:0]        ang;
    } lon_t;

    typedef struct packed {
        logic signed [LAT_W-1:0] x;
        logic signed [LAT_W-1:0] y;
        logic [ANG_W-1:0]        ang;
    } lat_t;

    typedef struct packed {
        logic pole;
        logic null_vec;
    } flags_t;

endpackage

/* rtl/b2e_if.sv */
// Channel interfaces for the bearing-to-equirectangular projection:
// bearing input, projected output and configuration write. Uses b2e_pkg.
`timescale 1ns / 1ps

interface b2e_bearing_if;
    logic valid;
    logic ready;
    logic signed [b2e_pkg::COORD_BITS-1:0] bearing_x;
    logic signed [b2e_pkg::COORD_BITS-1:0] bearing_y;
    logic signed [b2e_pkg::COORD_BITS-1:0] bearing_z;

    modport source (output valid, bearing_x, bearing_y, bearing_z, input ready);
    modport sink (input valid, bearing_x, bearing_y, bearing_z, output ready);
endinterface

interface b2e_proj_if;
    logic valid;
    logic ready;
    logic [b2e_pkg::U_BITS-1:0] u_coord;
    logic [b2e_pkg::V_BITS-1:0] v_coord;
    logic                       ok;

    modport source (output valid, u_coord, v_coord, ok, input ready);
    modport sink (input valid, u_coord, v_coord, ok, output ready);
endinterface

interface b2e_cfg_if;
    logic                          valid;
    logic                          ready;
    b2e_pkg::cfg_reg_t             index;
    logic [b2e_pkg::DIM_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/bearing_to_equirectangular.sv */
// Top level of the bearing-to-equirectangular projection: pipelined integer
// square root and two CORDIC vectoring chains. Uses b2e_pkg and b2e_if.sv.
//
//   channel   direction  contents
//   cfg       in         register index, 14-bit data (always ready)
//   bearing   in         bearing_x, bearing_y, bearing_z
//   proj      out        u_coord, v_coord, ok
//
// One transaction enters per cycle while the output does not stall. Stages:
// input register, squares, sum, 32 square-root stages, latitude setup, 18
// latitude CORDIC stages, angle fix-up and the output multiply. Longitude
// CORDIC runs beside the first 18 square-root stages. Reset clears valid
// bits and loads the default dimensions. An output stall holds every stage.
`timescale 1ns / 1ps
`include "bearing_to_equirectangular_assert.svh"

module bearing_to_equirectangular (
    input  logic       clk,
    input  logic       rst_n,
    b2e_cfg_if.sink    cfg,
    b2e_bearing_if.sink bearing,
    b2e_proj_if.source proj
);

    localparam int LAST_SQ  = b2e_pkg::SQRT_STAGES - 1;
    localparam int LAST_LAT = b2e_pkg::CORDIC_STAGES - 1;

    function automatic b2e_pkg::lon_t lon_step(input b2e_pkg::lon_t cur,
                                               input int unsigned s);
        logic signed [b2e_pkg::LON_W-1:0] dx;
        logic signed [b2e_pkg::LON_W-1:0] dy;
        b2e_pkg::lon_t nxt;
        dx = $signed(cur.y) >>> s;
        dy = $signed(cur.x) >>> s;
        nxt = cur;
        if ($signed(cur.y) > 0)
        begin
            nxt.x   = cur.x + dx;
            nxt.y   = cur.y - dy;
            nxt.ang = cur.ang + b2e_pkg::ATAN_TABLE[s[4:0]];
        end
        else
        begin
            nxt.x   = cur.x - dx;
            nxt.y   = cur.y + dy;
            nxt.ang = cur.ang - b2e_pkg::ATAN_TABLE[s[4:0]];
        end
        return nxt;
    endfunction

    function automatic b2e_pkg::lat_t lat_step(input b2e_pkg::lat_t cur,
                                               input int unsigned s);
        logic signed [b2e_pkg::LAT_W-1:0] dx;
        logic signed [b2e_pkg::LAT_W-1:0] dy;
        b2e_pkg::lat_t nxt;
        dx = $signed(cur.y) >>> s;
        dy = $signed(cur.x) >>> s;
        nxt = cur;
        if ($signed(cur.y) > 0)
        begin
            nxt.x   = cur.x + dx;
            nxt.y   = cur.y - dy;
            nxt.ang = cur.ang + b2e_pkg::ATAN_TABLE[s[4:0]];
        end
        else
        begin
            nxt.x   = cur.x - dx;
            nxt.y   = cur.y + dy;
            nxt.ang = cur.ang - b2e_pkg::ATAN_TABLE[s[4:0]];
        end
        return nxt;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [b2e_pkg::DIM_BITS-1:0] width_reg;
    logic [b2e_pkg::DIM_BITS-1:0] height_reg;
    logic [b2e_pkg::DIM_BITS-1:0] w_eff;
    logic [b2e_pkg::DIM_BITS-1:0] h_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= b2e_pkg::DIM_BITS'(1024);
            height_reg <= b2e_pkg::DIM_BITS'(512);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                b2e_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                b2e_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign w_eff = (width_reg > b2e_pkg::DIM_BITS'(b2e_pkg::MAX_DIM))
                 ? b2e_pkg::DIM_BITS'(b2e_pkg::MAX_DIM) : width_reg;
    assign h_eff = (height_reg > b2e_pkg::DIM_BITS'(b2e_pkg::MAX_DIM))
                 ? b2e_pkg::DIM_BITS'(b2e_pkg::MAX_DIM) : height_reg;

    // ------------------------------------------------------------------
    // Pipeline enable: every stage advances unless the output is blocked.
    // ------------------------------------------------------------------
    logic en;
    logic out_vld_reg;

    assign en            = !out_vld_reg || proj.ready;
    assign bearing.ready = en;

    // Stage A: input register
    logic                                  a_vld_reg;
    logic signed [b2e_pkg::COORD_BITS-1:0] a_x_reg;
    logic signed [b2e_pkg::COORD_BITS-1:0] a_y_reg;
    logic signed [b2e_pkg::COORD_BITS-1:0] a_z_reg;

    // Stage B: squares, scaled z, longitude CORDIC start
    logic                                  b_vld_reg;
    logic [b2e_pkg::SQ_W-1:0]              b_sqx_reg;
    logic [b2e_pkg::SQ_W-1:0]              b_sqy_reg;
    logic signed [b2e_pkg::ZS_W-1:0]       b_zs_reg;
    b2e_pkg::lon_t                         b_lon_reg;
    b2e_pkg::flags_t                       b_flg_reg;

    logic [b2e_pkg::COORD_BITS-1:0]        ax;
    logic [b2e_pkg::COORD_BITS-1:0]        ay;
    logic [b2e_pkg::SQ_W-1:0]              b_sqx_next;
    logic [b2e_pkg::SQ_W-1:0]              b_sqy_next;
    logic signed [b2e_pkg::ZS_W-1:0]       b_zs_next;
    b2e_pkg::lon_t                         b_lon_next;
    b2e_pkg::flags_t                       b_flg_next;
    logic signed [b2e_pkg::LON_W-1:0]      xe;
    logic signed [b2e_pkg::LON_W-1:0]      ye;

    // Stage C: radicand
    logic                                  c_vld_reg;
    logic [b2e_pkg::SUM_W-1:0]             c_rem_reg;
    logic signed [b2e_pkg::ZS_W-1:0]       c_zs_reg;
    b2e_pkg::lon_t                         c_lon_reg;
    b2e_pkg::flags_t                       c_flg_reg;
    logic [b2e_pkg::SUM_W-1:0]             c_rem_next;

    assign ax = a_x_reg[b2e_pkg::COORD_BITS-1] ? b2e_pkg::COORD_BITS'(-a_x_reg)
                                               : b2e_pkg::COORD_BITS'(a_x_reg);
    assign ay = a_y_reg[b2e_pkg::COORD_BITS-1] ? b2e_pkg::COORD_BITS'(-a_y_reg)
                                               : b2e_pkg::COORD_BITS'(a_y_reg);
    assign b_sqx_next = b2e_pkg::SQ_W'(ax) * b2e_pkg::SQ_W'(ax);
    assign b_sqy_next = b2e_pkg::SQ_W'(ay) * b2e_pkg::SQ_W'(ay);
    assign b_zs_next  = $signed({a_z_reg, {b2e_pkg::LAT_GUARD{1'b0}}});

    assign xe = $signed({{(b2e_pkg::LON_W - b2e_pkg::COORD_BITS - b2e_pkg::PRESCALE)
                          {a_x_reg[b2e_pkg::COORD_BITS-1]}},
                         a_x_reg, {b2e_pkg::PRESCALE{1'b0}}});
    assign ye = $signed({{(b2e_pkg::LON_W - b2e_pkg::COORD_BITS - b2e_pkg::PRESCALE)
                          {a_y_reg[b2e_pkg::COORD_BITS-1]}},
                         a_y_reg, {b2e_pkg::PRESCALE{1'b0}}});

    always_comb
    begin
        // A vector in the left half plane is turned by pi first.
        if (a_x_reg[b2e_pkg::COORD_BITS-1])
        begin
            b_lon_next.x   = -xe;
            b_lon_next.y   = -ye;
            b_lon_next.ang = b2e_pkg::ANG_HALF;
        end
        else
        begin
            b_lon_next.x   = xe;
            b_lon_next.y   = ye;
            b_lon_next.ang = '0;
        end
        b_flg_next.pole     = (a_x_reg == '0) && (a_y_reg == '0);
        b_flg_next.null_vec = b_flg_next.pole && (a_z_reg == '0);
    end

    assign c_rem_next = (b2e_pkg::SUM_W'(b_sqx_reg) + b2e_pkg::SUM_W'(b_sqy_reg))
                        << (2 * b2e_pkg::LAT_GUARD);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg   <= bearing.bearing_x;
            a_y_reg   <= bearing.bearing_y;
            a_z_reg   <= bearing.bearing_z;
            b_sqx_reg <= b_sqx_next;
            b_sqy_reg <= b_sqy_next;
            b_zs_reg  <= b_zs_next;
            b_lon_reg <= b_lon_next;
            b_flg_reg <= b_flg_next;
            c_rem_reg <= c_rem_next;
            c_zs_reg  <= b_zs_reg;
            c_lon_reg <= b_lon_reg;
            c_flg_reg <= b_flg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root, one result bit per stage, with the longitude CORDIC
    // iterating alongside.
    // ------------------------------------------------------------------
    logic [b2e_pkg::SUM_W-1:0]       sq_rem_reg  [b2e_pkg::SQRT_STAGES];
    logic [b2e_pkg::SUM_W-1:0]       sq_root_reg [b2e_pkg::SQRT_STAGES];
    logic signed [b2e_pkg::ZS_W-1:0] sq_zs_reg   [b2e_pkg::SQRT_STAGES];
    b2e_pkg::lon_t                   sq_lon_reg  [b2e_pkg::SQRT_STAGES];
    b2e_pkg::flags_t                 sq_flg_reg  [b2e_pkg::SQRT_STAGES];
    logic [b2e_pkg::SQRT_STAGES-1:0] sq_vld_reg;

    for (genvar k = 0; k < b2e_pkg::SQRT_STAGES; k++)
    begin : g_sqrt
        localparam logic [b2e_pkg::SUM_W-1:0] BIT_K =
            b2e_pkg::SUM_W'(1) << (b2e_pkg::SUM_W - 2 - 2 * k);

        logic [b2e_pkg::SUM_W-1:0]       rem_prev;
        logic [b2e_pkg::SUM_W-1:0]       root_prev;
        logic signed [b2e_pkg::ZS_W-1:0] zs_prev;
        b2e_pkg::lon_t                   lon_prev;
        b2e_pkg::flags_t                 flg_prev;
        logic                            vld_prev;
        logic [b2e_pkg::SUM_W-1:0]       trial;
        logic [b2e_pkg::SUM_W-1:0]       rem_next;
        logic [b2e_pkg::SUM_W-1:0]       root_next;
        b2e_pkg::lon_t                   lon_next;

        if (k == 0)
        begin : g_first
            assign rem_prev  = c_rem_reg;
            assign root_prev = '0;
            assign zs_prev   = c_zs_reg;
            assign lon_prev  = c_lon_reg;
            assign flg_prev  = c_flg_reg;
            assign vld_prev  = c_vld_reg;
        end
        else
        begin : g_rest
            assign rem_prev  = sq_rem_reg[k-1];
            assign root_prev = sq_root_reg[k-1];
            assign zs_prev   = sq_zs_reg[k-1];
            assign lon_prev  = sq_lon_reg[k-1];
            assign flg_prev  = sq_flg_reg[k-1];
            assign vld_prev  = sq_vld_reg[k-1];
        end

        assign trial = root_prev + BIT_K;

        always_comb
        begin
            if (rem_prev >= trial)
            begin
                rem_next  = rem_prev - trial;
                root_next = (root_prev >> 1) + BIT_K;
            end
            else
            begin
                rem_next  = rem_prev;
                root_next = root_prev >> 1;
            end
        end

        if (k < b2e_pkg::CORDIC_STAGES)
        begin : g_lon
            assign lon_next = lon_step(lon_prev, k);
        end
        else
        begin : g_lon_hold
            assign lon_next = lon_prev;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k] <= 1'b0;
            else if (en)
                sq_vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_zs_reg[k]   <= zs_prev;
                sq_lon_reg[k]  <= lon_next;
                sq_flg_reg[k]  <= flg_prev;
            end
        end
    end

    // ------------------------------------------------------------------
    // Latitude CORDIC on (hypot, z)
    // ------------------------------------------------------------------
    logic                          l0_vld_reg;
    b2e_pkg::lat_t                 l0_lat_reg;
    logic [b2e_pkg::ANG_W-1:0]     l0_lon_reg;
    b2e_pkg::flags_t               l0_flg_reg;
    b2e_pkg::lat_t                 l0_lat_next;
    logic [b2e_pkg::ROOT_W-1:0]    root_fin;
    logic signed [b2e_pkg::ZS_W-1:0] zs_fin;

    assign root_fin = sq_root_reg[LAST_SQ][b2e_pkg::ROOT_W-1:0];
    assign zs_fin   = sq_zs_reg[LAST_SQ];

    // The radius is never negative, so no half-plane turn is needed here.
    assign l0_lat_next.x = $signed({{(b2e_pkg::LAT_W - b2e_pkg::ROOT_W - b2e_pkg::PRESCALE)
                                     {1'b0}}, root_fin, {b2e_pkg::PRESCALE{1'b0}}});
    assign l0_lat_next.y = $signed({{(b2e_pkg::LAT_W - b2e_pkg::ZS_W - b2e_pkg::PRESCALE)
                                     {zs_fin[b2e_pkg::ZS_W-1]}},
                                    zs_fin, {b2e_pkg::PRESCALE{1'b0}}});
    assign l0_lat_next.ang = '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l0_lat_reg <= l0_lat_next;
            // At a pole the longitude is defined as zero.
            l0_lon_reg <= sq_flg_reg[LAST_SQ].pole ? '0 : sq_lon_reg[LAST_SQ].ang;
            l0_flg_reg <= sq_flg_reg[LAST_SQ];
        end
    end

    b2e_pkg::lat_t                     lt_lat_reg [b2e_pkg::CORDIC_STAGES];
    logic [b2e_pkg::ANG_W-1:0]         lt_lon_reg [b2e_pkg::CORDIC_STAGES];
    b2e_pkg::flags_t                   lt_flg_reg [b2e_pkg::CORDIC_STAGES];
    logic [b2e_pkg::CORDIC_STAGES-1:0] lt_vld_reg;

    for (genvar j = 0; j < b2e_pkg::CORDIC_STAGES; j++)
    begin : g_lat
        b2e_pkg::lat_t             lat_prev;
        logic [b2e_pkg::ANG_W-1:0] lon_prev;
        b2e_pkg::flags_t           flg_prev;
        logic                      vld_prev;

        if (j == 0)
        begin : g_first
            assign lat_prev = l0_lat_reg;
            assign lon_prev = l0_lon_reg;
            assign flg_prev = l0_flg_reg;
            assign vld_prev = l0_vld_reg;
        end
        else
        begin : g_rest
            assign lat_prev = lt_lat_reg[j-1];
            assign lon_prev = lt_lon_reg[j-1];
            assign flg_prev = lt_flg_reg[j-1];
            assign vld_prev = lt_vld_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lt_vld_reg[j] <= 1'b0;
            else if (en)
                lt_vld_reg[j] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lt_lat_reg[j] <= lat_step(lat_prev, j);
                lt_lon_reg[j] <= lon_prev;
                lt_flg_reg[j] <= flg_prev;
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle fix-up: colatitude clamp and longitude offset
    // ------------------------------------------------------------------
    logic                              f_vld_reg;
    logic [b2e_pkg::D_W-1:0]           f_d_reg;
    logic [b2e_pkg::ANG_W-1:0]         f_lonoff_reg;
    b2e_pkg::flags_t                   f_flg_reg;
    logic signed [b2e_pkg::ANG_W+1:0]  d_wide;
    logic [b2e_pkg::D_W-1:0]           f_d_next;

    localparam logic signed [b2e_pkg::ANG_W+1:0] QUARTER =
        (b2e_pkg::ANG_W+2)'(1) << (b2e_pkg::ANG_W - 2);
    localparam logic signed [b2e_pkg::ANG_W+1:0] HALF =
        (b2e_pkg::ANG_W+2)'(1) << (b2e_pkg::ANG_W - 1);

    assign d_wide = QUARTER - (b2e_pkg::ANG_W+2)'($signed(lt_lat_reg[LAST_LAT].ang));

    always_comb
    begin
        priority if (d_wide < 0)
            f_d_next = '0;
        else if (d_wide > HALF)
            f_d_next = b2e_pkg::D_W'(HALF);
        else
            f_d_next = d_wide[b2e_pkg::D_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_d_reg      <= f_d_next;
            f_lonoff_reg <= lt_lon_reg[LAST_LAT] + b2e_pkg::ANG_HALF;
            f_flg_reg    <= lt_flg_reg[LAST_LAT];
        end
    end

    // ------------------------------------------------------------------
    // Output: scale by the image dimensions
    // ------------------------------------------------------------------
    logic [b2e_pkg::U_BITS-1:0]  out_u_reg;
    logic [b2e_pkg::V_BITS-1:0]  out_v_reg;
    logic                        out_ok_reg;
    logic [b2e_pkg::PROD_W-1:0]  u_prod;
    logic [b2e_pkg::PROD_W-1:0]  v_prod;
    logic                        ok_next;

    assign u_prod  = b2e_pkg::PROD_W'(w_eff) * b2e_pkg::PROD_W'(f_lonoff_reg);
    assign v_prod  = b2e_pkg::PROD_W'(h_eff) * b2e_pkg::PROD_W'(f_d_reg);
    assign ok_next = !f_flg_reg.null_vec && (w_eff != '0) && (h_eff != '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_u_reg  <= ok_next
                        ? u_prod[b2e_pkg::ANG_W-b2e_pkg::FRAC_BITS +: b2e_pkg::U_BITS]
                        : '0;
            out_v_reg  <= ok_next
                        ? v_prod[b2e_pkg::ANG_W-1-b2e_pkg::FRAC_BITS +: b2e_pkg::V_BITS]
                        : '0;
            out_ok_reg <= ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            l0_vld_reg  <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg   <= bearing.valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            l0_vld_reg  <= sq_vld_reg[LAST_SQ];
            f_vld_reg   <= lt_vld_reg[LAST_LAT];
            out_vld_reg <= f_vld_reg;
        end
    end

    assign proj.valid   = out_vld_reg;
    assign proj.u_coord = out_u_reg;
    assign proj.v_coord = out_v_reg;
    assign proj.ok      = out_ok_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `B2E_ASSERT_IMPL(a_reject_zeroes, proj.valid && !proj.ok, proj.u_coord == '0 && proj.v_coord == '0)
    `B2E_ASSERT_NEXT(a_stall_holds, !en, $stable(sq_vld_reg) && $stable(lt_vld_reg))
    `B2E_ASSERT_NEXT(a_fixup_to_out, en && f_vld_reg, out_vld_reg)

endmodule
